// ===== hw/rtl/tmvp_pkg.sv =====
// ----------------------------------------------------------------------------
// tmvp_pkg
// Shared types and constants of the topology mirror vertex pairing block.
// ----------------------------------------------------------------------------
package tmvp_pkg;

    localparam int CFG_W  = 11;
    localparam int VIDX_W = 10;
    localparam int HASH_W = 32;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic              command;
        logic [VIDX_W-1:0] vert_a;
        logic [VIDX_W-1:0] vert_b;
        logic              last_edge;
        logic [VIDX_W-1:0] query_vertex;
    } t_item;

    typedef struct packed {
        logic [VIDX_W-1:0] vertex_index;
        logic [VIDX_W-1:0] mirror_index;
        logic              has_mirror;
        logic              status;
    } t_result;

    typedef enum logic [4:0] {
        ST_IDLE, ST_INIT, ST_EDGE_RD, ST_EDGE_CHK, ST_MUL1, ST_WR1, ST_RD2,
        ST_MUL2, ST_WR2, ST_COPY_RD, ST_COPY_WR, ST_DIST_RDV, ST_DIST_LATV,
        ST_DIST_RDU, ST_DIST_CMP, ST_DECIDE, ST_GRP_RDV, ST_GRP_LATV,
        ST_GRP_RDU, ST_GRP_CMP, ST_GRP_WR, ST_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_IDLE, OP_INIT, OP_EDGE_RD, OP_EDGE_CHK, OP_MUL1, OP_WR1, OP_RD2,
        OP_MUL2, OP_WR2, OP_COPY_RD, OP_COPY_WR, OP_DIST_RDV, OP_DIST_LATV,
        OP_DIST_RDU, OP_DIST_CMP, OP_DECIDE, OP_GRP_RDV, OP_GRP_LATV,
        OP_GRP_RDU, OP_GRP_CMP, OP_GRP_WR, OP_DONE
    } t_op;

    typedef struct packed {
        t_op  op;
        logic busy;
    } t_dp_cmd;

    typedef struct packed {
        logic last_v;
        logic edges_done;
        logic skip;
        logic deg;
        logic v_zero;
        logic match;
        logic u_last_dist;
        logic u_last;
        logic stop;
    } t_dp_sts;

endpackage

// ===== hw/rtl/tmvp_ctrl.sv =====
// ----------------------------------------------------------------------------
// tmvp_ctrl
// Sequencer of the analysis: degree count, hash passes, distinct count and
// pairing, driven by datapath status.
// ----------------------------------------------------------------------------
module tmvp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  tmvp_pkg::t_dp_sts i_sts,
    output tmvp_pkg::t_dp_cmd o_cmd
);

    tmvp_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tmvp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tmvp_pkg::ST_IDLE: begin
                if (i_go) n_state = tmvp_pkg::ST_INIT;
            end
            tmvp_pkg::ST_INIT: begin
                if (i_sts.last_v) n_state = tmvp_pkg::ST_EDGE_RD;
            end
            tmvp_pkg::ST_EDGE_RD: begin
                if (i_sts.edges_done) begin
                    n_state = i_sts.deg ? tmvp_pkg::ST_COPY_RD : tmvp_pkg::ST_DIST_RDV;
                end else begin
                    n_state = tmvp_pkg::ST_EDGE_CHK;
                end
            end
            tmvp_pkg::ST_EDGE_CHK: begin
                n_state = i_sts.skip ? tmvp_pkg::ST_EDGE_RD : tmvp_pkg::ST_MUL1;
            end
            tmvp_pkg::ST_MUL1:    n_state = tmvp_pkg::ST_WR1;
            tmvp_pkg::ST_WR1:     n_state = tmvp_pkg::ST_RD2;
            tmvp_pkg::ST_RD2:     n_state = tmvp_pkg::ST_MUL2;
            tmvp_pkg::ST_MUL2:    n_state = tmvp_pkg::ST_WR2;
            tmvp_pkg::ST_WR2:     n_state = tmvp_pkg::ST_EDGE_RD;
            tmvp_pkg::ST_COPY_RD: n_state = tmvp_pkg::ST_COPY_WR;
            tmvp_pkg::ST_COPY_WR: begin
                n_state = i_sts.last_v ? tmvp_pkg::ST_EDGE_RD : tmvp_pkg::ST_COPY_RD;
            end
            tmvp_pkg::ST_DIST_RDV: n_state = tmvp_pkg::ST_DIST_LATV;
            tmvp_pkg::ST_DIST_LATV: begin
                if (i_sts.v_zero) begin
                    n_state = i_sts.last_v ? tmvp_pkg::ST_DECIDE : tmvp_pkg::ST_DIST_RDV;
                end else begin
                    n_state = tmvp_pkg::ST_DIST_RDU;
                end
            end
            tmvp_pkg::ST_DIST_RDU: n_state = tmvp_pkg::ST_DIST_CMP;
            tmvp_pkg::ST_DIST_CMP: begin
                if (i_sts.match || i_sts.u_last_dist) begin
                    n_state = i_sts.last_v ? tmvp_pkg::ST_DECIDE : tmvp_pkg::ST_DIST_RDV;
                end else begin
                    n_state = tmvp_pkg::ST_DIST_RDU;
                end
            end
            tmvp_pkg::ST_DECIDE: begin
                n_state = i_sts.stop ? tmvp_pkg::ST_GRP_RDV : tmvp_pkg::ST_COPY_RD;
            end
            tmvp_pkg::ST_GRP_RDV:  n_state = tmvp_pkg::ST_GRP_LATV;
            tmvp_pkg::ST_GRP_LATV: n_state = tmvp_pkg::ST_GRP_RDU;
            tmvp_pkg::ST_GRP_RDU:  n_state = tmvp_pkg::ST_GRP_CMP;
            tmvp_pkg::ST_GRP_CMP: begin
                n_state = i_sts.u_last ? tmvp_pkg::ST_GRP_WR : tmvp_pkg::ST_GRP_RDU;
            end
            tmvp_pkg::ST_GRP_WR: begin
                n_state = i_sts.last_v ? tmvp_pkg::ST_DONE : tmvp_pkg::ST_GRP_RDV;
            end
            tmvp_pkg::ST_DONE: n_state = tmvp_pkg::ST_IDLE;
            default:           n_state = tmvp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.busy = (r_state != tmvp_pkg::ST_IDLE);
        unique case (r_state)
            tmvp_pkg::ST_IDLE:      o_cmd.op = tmvp_pkg::OP_IDLE;
            tmvp_pkg::ST_INIT:      o_cmd.op = tmvp_pkg::OP_INIT;
            tmvp_pkg::ST_EDGE_RD:   o_cmd.op = tmvp_pkg::OP_EDGE_RD;
            tmvp_pkg::ST_EDGE_CHK:  o_cmd.op = tmvp_pkg::OP_EDGE_CHK;
            tmvp_pkg::ST_MUL1:      o_cmd.op = tmvp_pkg::OP_MUL1;
            tmvp_pkg::ST_WR1:       o_cmd.op = tmvp_pkg::OP_WR1;
            tmvp_pkg::ST_RD2:       o_cmd.op = tmvp_pkg::OP_RD2;
            tmvp_pkg::ST_MUL2:      o_cmd.op = tmvp_pkg::OP_MUL2;
            tmvp_pkg::ST_WR2:       o_cmd.op = tmvp_pkg::OP_WR2;
            tmvp_pkg::ST_COPY_RD:   o_cmd.op = tmvp_pkg::OP_COPY_RD;
            tmvp_pkg::ST_COPY_WR:   o_cmd.op = tmvp_pkg::OP_COPY_WR;
            tmvp_pkg::ST_DIST_RDV:  o_cmd.op = tmvp_pkg::OP_DIST_RDV;
            tmvp_pkg::ST_DIST_LATV: o_cmd.op = tmvp_pkg::OP_DIST_LATV;
            tmvp_pkg::ST_DIST_RDU:  o_cmd.op = tmvp_pkg::OP_DIST_RDU;
            tmvp_pkg::ST_DIST_CMP:  o_cmd.op = tmvp_pkg::OP_DIST_CMP;
            tmvp_pkg::ST_DECIDE:    o_cmd.op = tmvp_pkg::OP_DECIDE;
            tmvp_pkg::ST_GRP_RDV:   o_cmd.op = tmvp_pkg::OP_GRP_RDV;
            tmvp_pkg::ST_GRP_LATV:  o_cmd.op = tmvp_pkg::OP_GRP_LATV;
            tmvp_pkg::ST_GRP_RDU:   o_cmd.op = tmvp_pkg::OP_GRP_RDU;
            tmvp_pkg::ST_GRP_CMP:   o_cmd.op = tmvp_pkg::OP_GRP_CMP;
            tmvp_pkg::ST_GRP_WR:    o_cmd.op = tmvp_pkg::OP_GRP_WR;
            tmvp_pkg::ST_DONE:      o_cmd.op = tmvp_pkg::OP_DONE;
            default:                o_cmd.op = tmvp_pkg::OP_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/tmvp_dp.sv =====
// ----------------------------------------------------------------------------
// tmvp_dp
// Datapath: edge store, hash tables, partner table, counters and the
// lookup response register.
// ----------------------------------------------------------------------------
module tmvp_dp #(
    parameter int MAX_VERTS = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  tmvp_pkg::t_dp_cmd                      i_cmd,
    output tmvp_pkg::t_dp_sts                      o_sts,
    input  logic                                   i_accept,
    input  tmvp_pkg::t_item                        i_item,
    input  logic [$clog2(MAX_VERTS+1)-1:0]         i_vc,
    output tmvp_pkg::t_result                      o_rsp,
    output logic                                   o_rsp_valid
);

    localparam int AW   = $clog2(MAX_VERTS);
    localparam int VC_W = $clog2(MAX_VERTS + 1);
    localparam int EW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW  = $clog2(MAX_EDGES + 1);
    localparam int PW   = $clog2(MAX_VERTS + MAX_EDGES + 2);
    localparam int HW   = tmvp_pkg::HASH_W;

    // storage
    logic [2*AW-1:0] m_edge [MAX_EDGES];
    logic [HW-1:0]   m_hc   [MAX_VERTS];
    logic [HW-1:0]   m_hp   [MAX_VERTS];
    logic [AW:0]     m_prt  [MAX_VERTS];

    // control registers
    logic [ECW-1:0]  r_etot, r_e, r_ecnt, r_ecnt_prev;
    logic [AW-1:0]   r_v, r_u, r_match;
    logic [VC_W-1:0] r_n, r_n_an, r_uniq, r_uniq_prev;
    logic [PW-1:0]   r_pass;
    logic [1:0]      r_gcnt;
    logic            r_deg, r_first, r_ready, r_rsp_valid;

    // payload registers
    logic [2*AW-1:0] r_ed_rd;
    logic [HW-1:0]   r_hc_rd, r_hp_rd, r_hval, r_prod, r_x1, r_hv;
    logic [AW:0]     r_prt_rd;
    logic [tmvp_pkg::VIDX_W-1:0] r_q;
    logic            r_ok, r_rdy_snap;

    tmvp_pkg::t_op   w_op;
    logic [AW-1:0]   w_a, w_b, w_hc_wa, w_hc_ra, w_hp_ra;
    logic [HW-1:0]   w_sum, w_hc_wd;
    logic [HW+PW-1:0] w_mul;
    logic            w_hc_we, w_load, w_load_ok, w_go, w_read;
    logic            w_last_v, w_u_last, w_u_last_dist, w_match;

    assign w_op   = i_cmd.op;
    assign w_a    = r_ed_rd[2*AW-1:AW];
    assign w_b    = r_ed_rd[AW-1:0];
    assign w_sum  = r_hval + r_prod;
    assign w_mul  = r_hp_rd * r_pass;
    assign w_load = i_accept && (i_item.command == tmvp_pkg::CMD_LOAD);
    assign w_read = i_accept && (i_item.command == tmvp_pkg::CMD_READ);
    assign w_go   = w_load && i_item.last_edge;
    assign w_load_ok = w_load && (32'(r_etot) < MAX_EDGES)
                     && (32'(i_item.vert_a) < 32'(i_vc))
                     && (32'(i_item.vert_b) < 32'(i_vc));

    assign w_last_v      = (VC_W'(r_v) + VC_W'(1)) == r_n;
    assign w_u_last      = (VC_W'(r_u) + VC_W'(1)) == r_n;
    assign w_u_last_dist = (VC_W'(r_u) + VC_W'(1)) == VC_W'(r_v);
    assign w_match       = (r_hc_rd == r_hv);

    always_comb begin
        o_sts.last_v      = w_last_v;
        o_sts.edges_done  = (r_e == r_etot);
        o_sts.skip        = (32'(w_a) >= 32'(r_n)) || (32'(w_b) >= 32'(r_n));
        o_sts.deg         = r_deg;
        o_sts.v_zero      = (r_v == '0);
        o_sts.match       = w_match;
        o_sts.u_last_dist = w_u_last_dist;
        o_sts.u_last      = w_u_last;
        o_sts.stop        = !r_first && (r_uniq <= r_uniq_prev) && (r_ecnt <= r_ecnt_prev);
    end

    // hash table port selection
    always_comb begin
        w_hc_we = 1'b0;
        w_hc_wa = r_v;
        w_hc_wd = '0;
        unique case (w_op)
            tmvp_pkg::OP_INIT: begin
                w_hc_we = 1'b1;
            end
            tmvp_pkg::OP_WR1: begin
                w_hc_we = 1'b1;
                w_hc_wa = w_a;
                w_hc_wd = w_sum;
            end
            tmvp_pkg::OP_WR2: begin
                w_hc_we = 1'b1;
                w_hc_wa = w_b;
                w_hc_wd = w_sum;
            end
            default: begin
                w_hc_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        unique case (w_op)
            tmvp_pkg::OP_EDGE_CHK:                     w_hc_ra = w_a;
            tmvp_pkg::OP_RD2:                          w_hc_ra = w_b;
            tmvp_pkg::OP_DIST_RDU, tmvp_pkg::OP_GRP_RDU: w_hc_ra = r_u;
            default:                                   w_hc_ra = r_v;
        endcase
        w_hp_ra = (w_op == tmvp_pkg::OP_RD2) ? w_a : w_b;
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (w_load_ok) m_edge[r_etot[EW-1:0]] <= {AW'(i_item.vert_a), AW'(i_item.vert_b)};
        if (w_op == tmvp_pkg::OP_EDGE_RD) r_ed_rd <= m_edge[r_e[EW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_hc_we) m_hc[w_hc_wa] <= w_hc_wd;
        r_hc_rd <= m_hc[w_hc_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_op == tmvp_pkg::OP_COPY_WR) m_hp[r_v] <= r_hc_rd;
        r_hp_rd <= m_hp[w_hp_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_op == tmvp_pkg::OP_GRP_WR) begin
            unique case (r_gcnt)
                2'd0:    m_prt[r_v] <= {1'b1, r_v};
                2'd1:    m_prt[r_v] <= {1'b1, r_match};
                default: m_prt[r_v] <= '0;
            endcase
        end
        if (w_read) r_prt_rd <= m_prt[AW'(i_item.query_vertex)];
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_op == tmvp_pkg::OP_MUL1 || w_op == tmvp_pkg::OP_MUL2) begin
            r_prod <= r_deg ? HW'(1) : w_mul[HW-1:0];
            r_hval <= r_hc_rd;
        end
        if (w_op == tmvp_pkg::OP_WR1) r_x1 <= w_sum;
        if (w_op == tmvp_pkg::OP_DIST_LATV || w_op == tmvp_pkg::OP_GRP_LATV) r_hv <= r_hc_rd;
        if (w_op == tmvp_pkg::OP_GRP_CMP && r_u != r_v && w_match) r_match <= r_u;
        if (w_read) begin
            r_q        <= i_item.query_vertex;
            r_rdy_snap <= r_ready;
            r_ok       <= r_ready && (32'(i_item.query_vertex) < 32'(r_n_an));
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_etot <= '0; r_e <= '0; r_ecnt <= '0; r_ecnt_prev <= '0;
            r_v <= '0; r_u <= '0; r_n <= VC_W'(1); r_n_an <= VC_W'(1);
            r_uniq <= '0; r_uniq_prev <= '0; r_pass <= PW'(1); r_gcnt <= '0;
            r_deg <= 1'b0; r_first <= 1'b1; r_ready <= 1'b0; r_rsp_valid <= 1'b0;
        end else begin
            r_rsp_valid <= w_read;
            if (w_load_ok) r_etot <= r_etot + ECW'(1);
            if (w_go) begin
                r_n     <= i_vc;
                r_v     <= '0;
                r_e     <= '0;
                r_deg   <= 1'b1;
                r_first <= 1'b1;
                r_pass  <= PW'(1);
            end
            unique case (w_op)
                tmvp_pkg::OP_INIT: begin
                    if (w_last_v) begin
                        r_v <= '0;
                        r_e <= '0;
                    end else begin
                        r_v <= r_v + AW'(1);
                    end
                end
                tmvp_pkg::OP_EDGE_RD: begin
                    if (r_e == r_etot) begin
                        r_v    <= '0;
                        r_uniq <= '0;
                        r_deg  <= 1'b0;
                    end
                end
                tmvp_pkg::OP_EDGE_CHK: begin
                    if (o_sts.skip) r_e <= r_e + ECW'(1);
                end
                tmvp_pkg::OP_WR2: begin
                    r_e <= r_e + ECW'(1);
                    if (!r_deg && w_a != w_b && r_x1 != w_sum) r_ecnt <= r_ecnt + ECW'(1);
                end
                tmvp_pkg::OP_COPY_WR: begin
                    if (w_last_v) begin
                        r_v    <= '0;
                        r_e    <= '0;
                        r_ecnt <= '0;
                    end else begin
                        r_v <= r_v + AW'(1);
                    end
                end
                tmvp_pkg::OP_DIST_LATV: begin
                    r_u <= '0;
                    if (r_v == '0) begin
                        r_uniq <= r_uniq + VC_W'(1);
                        r_v    <= w_last_v ? '0 : r_v + AW'(1);
                    end
                end
                tmvp_pkg::OP_DIST_CMP: begin
                    if (w_match || w_u_last_dist) begin
                        if (!w_match) r_uniq <= r_uniq + VC_W'(1);
                        r_v <= w_last_v ? '0 : r_v + AW'(1);
                    end else begin
                        r_u <= r_u + AW'(1);
                    end
                end
                tmvp_pkg::OP_DECIDE: begin
                    r_v <= '0;
                    if (!o_sts.stop) begin
                        r_uniq_prev <= r_uniq;
                        r_ecnt_prev <= r_ecnt;
                        r_first     <= 1'b0;
                        r_pass      <= r_pass + PW'(1);
                    end
                end
                tmvp_pkg::OP_GRP_LATV: begin
                    r_u    <= '0;
                    r_gcnt <= '0;
                end
                tmvp_pkg::OP_GRP_CMP: begin
                    if (r_u != r_v && w_match && r_gcnt != 2'd2) r_gcnt <= r_gcnt + 2'd1;
                    if (!w_u_last) r_u <= r_u + AW'(1);
                end
                tmvp_pkg::OP_GRP_WR: begin
                    if (!w_last_v) r_v <= r_v + AW'(1);
                end
                tmvp_pkg::OP_DONE: begin
                    r_ready <= 1'b1;
                    r_n_an  <= r_n;
                    r_etot  <= '0;
                    r_e     <= '0;
                end
                default: begin
                    r_ready <= r_ready;
                end
            endcase
        end
    end

    assign o_rsp_valid        = r_rsp_valid;
    assign o_rsp.vertex_index = r_q;
    assign o_rsp.status       = !r_rdy_snap;
    assign o_rsp.has_mirror   = r_ok && r_prt_rd[AW];
    assign o_rsp.mirror_index = (r_ok && r_prt_rd[AW])
                              ? tmvp_pkg::VIDX_W'(r_prt_rd[AW-1:0]) : '0;

`ifndef SYNTHESIS
    a_rsp_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_valid |-> $past(w_read))
        else $error("response without an accepted read");
    a_edge_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e <= r_etot)
        else $error("edge pointer beyond edge count");
    a_grp_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_op == tmvp_pkg::OP_GRP_CMP) |-> (32'(r_u) < 32'(r_n)))
        else $error("group scan beyond vertex count");
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_ok |-> !i_cmd.busy)
        else $error("edge stored during analysis");
`endif

endmodule

// ===== hw/rtl/topology_mirror_vertex_pairing.sv =====
// ----------------------------------------------------------------------------
// topology_mirror_vertex_pairing
// Loads a mesh edge list, hashes vertex topology pass by pass and pairs
// vertices of equal hash as mirror partners; answers partner lookups.
// ----------------------------------------------------------------------------
// channel   direction  handshake                       payload
// item      in         start & !busy                   i_item (t_item)
// result    out        o_rsp_valid, one-cycle strobe   o_rsp (t_result)
// config    in         i_cfg_valid & o_cfg_ready       i_cfg_data (vertex_count)
//
// Edge loads and lookups are taken one per cycle while busy is low; a lookup
// answers on the cycle after it is accepted and back-to-back lookups are
// answered back to back. The item that carries last_edge starts the analysis,
// and busy stays high while it runs. The hash tables have one read and one
// write port each, and the distinct count and the pairing compare vertices
// against each other.
// Reset is synchronous and needs no clearing pass. The receiver cannot stall.
module topology_mirror_vertex_pairing #(
    parameter int MAX_VERTS = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  tmvp_pkg::t_item              i_item,
    output tmvp_pkg::t_result            o_rsp,
    output logic                         o_rsp_valid,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [tmvp_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int VC_W = $clog2(MAX_VERTS + 1);

    logic [VC_W-1:0]   r_vc;
    logic              w_accept, w_go;
    tmvp_pkg::t_dp_cmd w_cmd;
    tmvp_pkg::t_dp_sts w_sts;

    assign busy        = w_cmd.busy;
    assign o_cfg_ready = !w_cmd.busy;
    assign w_accept    = start && !w_cmd.busy;
    // the edge that carries last_edge hands the edge list to the sequencer
    assign w_go        = w_accept && (i_item.command == tmvp_pkg::CMD_LOAD)
                       && i_item.last_edge;

    // vertex count: clamp zero up to one and anything above capacity down
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= VC_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_data == '0) begin
                r_vc <= VC_W'(1);
            end else if (32'(i_cfg_data) > MAX_VERTS) begin
                r_vc <= VC_W'(MAX_VERTS);
            end else begin
                r_vc <= VC_W'(i_cfg_data);
            end
        end
    end

    tmvp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    tmvp_dp #(
        .MAX_VERTS (MAX_VERTS),
        .MAX_EDGES (MAX_EDGES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_accept    (w_accept),
        .i_item      (i_item),
        .i_vc        (r_vc),
        .o_rsp       (o_rsp),
        .o_rsp_valid (o_rsp_valid)
    );

endmodule

// ===== bench/topology_mirror_vertex_pairing_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// topology_mirror_vertex_pairing_test
// Drives edge loads, analysis starts and partner lookups into the mirror
// pairing block with random gaps. A local model of the hash passes predicts
// every lookup. Each answer is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module topology_mirror_vertex_pairing_test;

    localparam int NUM_VERTS   = 1024;
    localparam int NUM_EDGES   = 4096;
    localparam int NUM_ITEMS   = 1450;
    localparam int CYCLE_LIMIT = 30000000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    tmvp_pkg::t_item   i_item = '0;
    tmvp_pkg::t_result o_rsp;
    logic      o_rsp_valid;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic [tmvp_pkg::CFG_W-1:0] i_cfg_data = '0;

    topology_mirror_vertex_pairing dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_rsp      (o_rsp),
        .o_rsp_valid(o_rsp_valid),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Mirror of the block's state.
    int unsigned       mesh_verts;
    int unsigned       edge_count;
    logic [tmvp_pkg::VIDX_W-1:0] edge_a [NUM_EDGES];
    logic [tmvp_pkg::VIDX_W-1:0] edge_b [NUM_EDGES];
    logic              partner_ok [NUM_VERTS];
    logic [tmvp_pkg::VIDX_W-1:0] partner_of [NUM_VERTS];
    logic              table_built;

    tmvp_pkg::t_result lookups_due[$];
    int unsigned mismatches;
    int unsigned answers_seen;
    int unsigned analyses_run;
    int unsigned items_sent;
    longint unsigned cycles;

    // Hash passes until neither the distinct-hash count nor the
    // differing-edge count grows, then pair vertices by final hash.
    task automatic analyse_mesh();
        logic [tmvp_pkg::HASH_W-1:0] cur [NUM_VERTS];
        logic [tmvp_pkg::HASH_W-1:0] prev [NUM_VERTS];
        logic [tmvp_pkg::HASH_W-1:0] sorted[$];
        longint distinct, diff_edges, distinct_last, diff_last;
        int unsigned pass_no, same_cnt, other;
        int unsigned n;
        n = mesh_verts;
        distinct_last = -1;
        diff_last = -1;
        pass_no = 1;
        for (int v = 0; v < n; v++) cur[v] = '0;
        for (int e = 0; e < edge_count; e++) begin
            if (edge_a[e] >= n || edge_b[e] >= n) continue;
            cur[edge_a[e]] += 1;
            cur[edge_b[e]] += 1;
        end
        for (int v = 0; v < n; v++) prev[v] = cur[v];
        forever begin
            diff_edges = 0;
            distinct = 1;
            for (int e = 0; e < edge_count; e++) begin
                if (edge_a[e] >= n || edge_b[e] >= n) continue;
                cur[edge_a[e]] += prev[edge_b[e]] * pass_no;
                cur[edge_b[e]] += prev[edge_a[e]] * pass_no;
                if (cur[edge_a[e]] != cur[edge_b[e]]) diff_edges++;
            end
            sorted = {};
            for (int v = 0; v < n; v++) sorted.push_back(cur[v]);
            sorted.sort();
            for (int v = 1; v < n; v++)
                if (sorted[v-1] != sorted[v]) distinct++;
            if (distinct <= distinct_last && diff_edges <= diff_last) break;
            distinct_last = distinct;
            diff_last = diff_edges;
            for (int v = 0; v < n; v++) prev[v] = cur[v];
            pass_no++;
        end
        for (int v = 0; v < NUM_VERTS; v++) begin
            partner_ok[v] = 1'b0;
            partner_of[v] = '0;
        end
        for (int v = 0; v < n; v++) begin
            same_cnt = 0;
            other = v;
            for (int u = 0; u < n; u++)
                if (cur[u] == cur[v]) begin
                    same_cnt++;
                    if (u != v) other = u;
                end
            if (same_cnt <= 2) begin
                partner_ok[v] = 1'b1;
                partner_of[v] = other[tmvp_pkg::VIDX_W-1:0];
            end
        end
        table_built = 1'b1;
        edge_count = 0;
        analyses_run++;
    endtask

    task automatic predict_item(input tmvp_pkg::t_item it);
        tmvp_pkg::t_result r;
        if (it.command == tmvp_pkg::CMD_LOAD) begin
            if (edge_count < NUM_EDGES && it.vert_a < mesh_verts && it.vert_b < mesh_verts)
            begin
                edge_a[edge_count] = it.vert_a;
                edge_b[edge_count] = it.vert_b;
                edge_count++;
            end
            if (it.last_edge) analyse_mesh();
        end else begin
            r = '0;
            r.vertex_index = it.query_vertex;
            if (!table_built) begin
                r.status = 1'b1;
            end else if (partner_ok[it.query_vertex]) begin
                r.mirror_index = partner_of[it.query_vertex];
                r.has_mirror = 1'b1;
            end
            lookups_due.push_back(r);
        end
    endtask

    // Hold the item until start & !busy at a rising edge; return at a falling edge.
    task automatic send_item(input tmvp_pkg::t_item it);
        int unsigned gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start = 1'b1;
        i_item = it;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        predict_item(it);
        items_sent++;
        @(negedge i_clk);
        start = 1'b0;
        i_item = $urandom();
    endtask

    task automatic load_edge(input int a, input int b, input bit last);
        tmvp_pkg::t_item it;
        it = $urandom();
        it.command = tmvp_pkg::CMD_LOAD;
        it.vert_a = tmvp_pkg::VIDX_W'(a);
        it.vert_b = tmvp_pkg::VIDX_W'(b);
        it.last_edge = last;
        send_item(it);
    endtask

    task automatic read_vertex(input int q);
        tmvp_pkg::t_item it;
        it = $urandom();
        it.command = tmvp_pkg::CMD_READ;
        it.query_vertex = tmvp_pkg::VIDX_W'(q);
        send_item(it);
    endtask

    // Write vertex_count only when the block is idle and all answers are in.
    task automatic write_vertex_count(input int value);
        int unsigned v;
        while (lookups_due.size() != 0 || busy) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = tmvp_pkg::CFG_W'(value);
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        v = value & 11'h7FF;
        if (v == 0) v = 1;
        if (v > NUM_VERTS) v = NUM_VERTS;
        mesh_verts = v;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        i_cfg_data = tmvp_pkg::CFG_W'($urandom());
    endtask

    // Check each answer against the oldest prediction.
    always @(posedge i_clk) begin
        tmvp_pkg::t_result want;
        if (i_rst_n && o_rsp_valid) begin
            answers_seen++;
            if (lookups_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected answer: got %p", o_rsp);
            end else begin
                want = lookups_due.pop_front();
                if (o_rsp.vertex_index !== want.vertex_index
                    || o_rsp.mirror_index !== want.mirror_index
                    || o_rsp.has_mirror !== want.has_mirror
                    || o_rsp.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("answer mismatch: expected %p, got %p", want, o_rsp);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic test_read_before_table();
        read_vertex(0);
        read_vertex(1023);
        read_vertex(512);
    endtask

    // Register value 0 acts as one vertex; a self loop is two updates.
    task automatic test_single_vertex();
        write_vertex_count(0);
        load_edge(0, 0, 1'b1);
        read_vertex(0);
        read_vertex(1);
        read_vertex(1023);
    endtask

    // Load at full size, including the top index, then lower the count.
    task automatic test_count_lowered();
        write_vertex_count(2047);
        load_edge(1023, 0, 1'b0);
        load_edge(1, 2, 1'b0);
        write_vertex_count(1024);
        load_edge(1023, 1023, 1'b0);
        load_edge(682, 341, 1'b0);
        write_vertex_count(6);
        load_edge(0, 5, 1'b1);
        for (int q = 0; q < 7; q++) read_vertex(q);
        read_vertex(1023);
    endtask

    // Out-of-range endpoint drops the edge but its last mark still starts.
    task automatic test_symmetric_path();
        write_vertex_count(5);
        for (int v = 0; v < 4; v++) load_edge(v, v + 1, 1'b0);
        load_edge(5, 1, 1'b1);
        for (int q = 0; q < 5; q++) read_vertex(q);
    endtask

    // Mostly well-formed meshes on small vertex counts, with stray reads,
    // out-of-range endpoints and sometimes a mirrored mesh to make pairs.
    task automatic test_random_meshes();
        int n, k, a, b;
        bit mirrored;
        while (items_sent < NUM_ITEMS) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(2, 16);
            write_vertex_count(n);
            k = $urandom_range(1, 14);
            mirrored = ($urandom_range(0, 1) == 1);
            for (int e = 0; e < k; e++) begin
                if ($urandom_range(0, 9) == 0) begin
                    read_vertex($urandom_range(0, 1023));
                end else begin
                    a = $urandom_range(0, n - 1);
                    b = $urandom_range(0, n - 1);
                    if ($urandom_range(0, 15) == 0) b = $urandom_range(0, 1023);
                    load_edge(a, b, 1'b0);
                    if (mirrored && e + 1 < k) load_edge(n - 1 - a, n - 1 - b, 1'b0);
                end
            end
            load_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1), 1'b1);
            repeat ($urandom_range(2, 12)) begin
                if ($urandom_range(0, 4) == 0) read_vertex($urandom_range(0, 1023));
                else read_vertex($urandom_range(0, n - 1));
            end
        end
    endtask

    initial begin
        int unsigned waited;
        mesh_verts = 1;
        edge_count = 0;
        table_built = 1'b0;
        mismatches = 0;
        answers_seen = 0;
        analyses_run = 0;
        items_sent = 0;
        cycles = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_read_before_table();
        test_single_vertex();
        test_count_lowered();
        test_symmetric_path();
        test_random_meshes();
        waited = 0;
        while ((lookups_due.size() != 0 || busy) && waited < 2000000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (20) @(negedge i_clk);
        $display("sent %0d items, %0d analyses, %0d lookups checked, %0d mismatches",
                 items_sent, analyses_run, answers_seen, mismatches);
        if (mismatches == 0 && lookups_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d lookups never answered", lookups_due.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== topology_mirror_vertex_pairing.f =====
hw/rtl/tmvp_pkg.sv
hw/rtl/tmvp_ctrl.sv
hw/rtl/tmvp_dp.sv
hw/rtl/topology_mirror_vertex_pairing.sv
bench/topology_mirror_vertex_pairing_test.sv
